### rtl/core/plce_pkg.sv
`default_nettype none

package plce_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COORD_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int NP_W       = 3;
   localparam int PROD_W     = 2 * COORD_W;
   localparam int DIV_STEPS  = PROD_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_POINTS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT0     = 3'd1;

   localparam logic [NP_W-1:0]       NUM_POINTS_RESET = 3'd2;
   localparam logic [CSR_DATA_W-1:0] POINT1_RESET     = 32'h8000_8000;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } point_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MULT,
      ST_LAUNCH,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               start;
      logic [PROD_W-1:0]  dividend;
      logic [COORD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic               valid;
      logic [COORD_W-1:0] value;
      logic               in_segment;
   } res_type;

endpackage

`default_nettype wire

### rtl/core/plce_div.sv
`default_nettype none

module plce_div (
   input  wire                 clock,
   input  wire                 reset,
   input  plce_pkg::div_req_type req,
   output plce_pkg::div_rsp_type rsp
);
   import plce_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [COORD_W-1:0]   rem_ff, rem_in;
   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [COORD_W-1:0]   divisor_ff, divisor_in;

   logic [COORD_W:0]     shifted;
   logic [COORD_W:0]     diff;
   logic                 fits;

   // One restoring step per cycle: the remainder always stays below the divisor.
   always_comb begin
      shifted    = {rem_ff, quo_ff[PROD_W-1]};
      diff       = shifted - {1'b0, divisor_ff};
      fits       = (shifted >= {1'b0, divisor_ff});
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (req.start) begin
         busy_in    = 1'b1;
         count_in   = DIV_CNT_W'(DIV_STEPS - 1);
         rem_in     = '0;
         quo_in     = req.dividend;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
         quo_in   = {quo_ff[PROD_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

### rtl/core/plce_engine.sv
`default_nettype none

module plce_engine #(
   parameter int MAX_POINTS = 6
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   input  wire  [plce_pkg::SAMPLE_W-1:0]        req_sample,
   output logic                                 req_stall,
   input  wire  [plce_pkg::NP_W-1:0]            num_points,
   input  plce_pkg::point_type                  points [MAX_POINTS],
   input  wire                                  out_free,
   output plce_pkg::res_type                    res
);
   import plce_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     k_ff, k_in;
   logic [SAMPLE_W-1:0]  t_ff, t_in;
   logic [COORD_W-1:0]   y0_ff, y0_in;
   logic [COORD_W-1:0]   dy_ff, dy_in;
   logic                 neg_ff, neg_in;
   logic [COORD_W-1:0]   dt_ff, dt_in;
   logic [COORD_W-1:0]   dx_ff, dx_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [COORD_W-1:0]   value_ff, value_in;
   logic                 inseg_ff, inseg_in;

   logic [NP_W-1:0]      n_used;
   logic [NP_W-1:0]      n_last;
   logic [IDX_W-1:0]     k_next;
   point_type            p0, p1;
   logic                 hit;
   logic                 last_seg;
   logic [COORD_W-1:0]   q;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   always_comb begin
      if (num_points < NP_W'(2)) begin
         n_used = NP_W'(2);
      end else if (num_points > NP_W'(MAX_POINTS)) begin
         n_used = NP_W'(MAX_POINTS);
      end else begin
         n_used = num_points;
      end
      n_last   = n_used - 1'b1;
      k_next   = k_ff + 1'b1;
      p0       = points[k_ff];
      p1       = points[k_next];
      hit      = (p0.x <= t_ff) && (t_ff <= p1.x);
      last_seg = ((NP_W'(k_ff) + NP_W'(2)) >= n_used);
      q        = div_rsp.quotient[COORD_W-1:0];
   end

   plce_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      t_in     = t_ff;
      y0_in    = y0_ff;
      dy_in    = dy_ff;
      neg_in   = neg_ff;
      dt_in    = dt_ff;
      dx_in    = dx_ff;
      prod_in  = prod_ff;
      value_in = value_ff;
      inseg_in = inseg_ff;
      req_stall        = (state_ff != ST_IDLE);
      div_req.start    = 1'b0;
      div_req.dividend = prod_ff;
      div_req.divisor  = dx_ff;
      res.valid        = 1'b0;
      res.value        = value_ff;
      res.in_segment   = inseg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               t_in     = req_sample;
               k_in     = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               y0_in    = p0.y;
               neg_in   = (p1.y < p0.y);
               dy_in    = (p1.y < p0.y) ? (p0.y - p1.y) : (p1.y - p0.y);
               dt_in    = t_ff - p0.x;
               dx_in    = p1.x - p0.x;
               inseg_in = 1'b1;
               if (p1.x == p0.x) begin
                  // A zero-width segment takes its left value.
                  value_in = p0.y;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_MULT;
               end
            end else if (last_seg) begin
               value_in = points[n_last[IDX_W-1:0]].y;
               inseg_in = 1'b0;
               state_in = ST_DONE;
            end else begin
               k_in = k_next;
            end
         end
         ST_MULT: begin
            prod_in  = PROD_W'(dy_ff) * PROD_W'(dt_ff);
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               value_in = neg_ff ? (y0_ff - q) : (y0_ff + q);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            res.valid = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
      t_ff     <= t_in;
      y0_ff    <= y0_in;
      dy_ff    <= dy_in;
      neg_ff   <= neg_in;
      dt_ff    <= dt_in;
      dx_ff    <= dx_in;
      prod_ff  <= prod_in;
      value_ff <= value_in;
      inseg_ff <= inseg_in;
   end

   // Since t - x0 never exceeds x1 - x0, the quotient fits in one coordinate.
   a_quotient_narrow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_rsp.done) |-> (div_rsp.quotient[PROD_W-1:COORD_W] == '0))
      else $error("quotient exceeds segment height");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((NP_W'(k_ff) + NP_W'(1)) < n_used))
      else $error("segment index beyond the points in use");

   a_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (state_ff == ST_IDLE))
      else $error("result handed off but sequencer did not return to idle");

endmodule

`default_nettype wire

### rtl/core/piecewise_linear_curve_eval_core.sv
`default_nettype none
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    req_sample[15:0]
// rsp       out        rsp_valid/stall    rsp_value[15:0], rsp_in_segment
// csr       in         csr_valid/ready    csr_index[2:0], csr_data[31:0]
//
// One sample is captured, then scanned segment by segment (one segment compare
// a cycle), then multiplied, launched, run through the bit-serial divider and
// handed off.
// A zero-width hit or a miss skips the multiply and divide.
// Reset clears the sequencer and the result slot and loads the curve registers with their defaults.
// A stalled result holds in the output register while the next sample is taken.

module piecewise_linear_curve_eval_core #(
   parameter int MAX_POINTS = 6
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [plce_pkg::SAMPLE_W-1:0]        req_sample,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [plce_pkg::COORD_W-1:0]         rsp_value,
   output logic                                 rsp_in_segment,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [plce_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [plce_pkg::CSR_DATA_W-1:0]      csr_data
);
   import plce_pkg::*;

   logic [NP_W-1:0]    num_points_ff, num_points_in;
   point_type          points_ff [MAX_POINTS];
   point_type          points_in [MAX_POINTS];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_inseg_ff, rsp_inseg_in;
   logic               csr_write;
   logic               out_free;
   res_type            res;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      num_points_in = num_points_ff;
      if (csr_write && csr_index == CSR_NUM_POINTS) begin
         num_points_in = csr_data[NP_W-1:0];
      end
      for (int i = 0; i < MAX_POINTS; i++) begin
         points_in[i] = points_ff[i];
         if (csr_write && csr_index == (CSR_POINT0 + CSR_IDX_W'(i))) begin
            points_in[i] = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff <= NUM_POINTS_RESET;
         for (int i = 0; i < MAX_POINTS; i++) begin
            points_ff[i] <= (i == 1) ? POINT1_RESET : '0;
         end
      end else begin
         num_points_ff <= num_points_in;
         for (int i = 0; i < MAX_POINTS; i++) begin
            points_ff[i] <= points_in[i];
         end
      end
   end

   // The result slot is free when empty or when its transfer happens now.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   plce_engine #(
      .MAX_POINTS (MAX_POINTS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_sample (req_sample),
      .req_stall  (req_stall),
      .num_points (num_points_ff),
      .points     (points_ff),
      .out_free   (out_free),
      .res        (res)
   );

   always_comb begin
      rsp_value_in = rsp_value_ff;
      rsp_inseg_in = rsp_inseg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (res.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res.value;
         rsp_inseg_in = res.in_segment;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_inseg_ff <= rsp_inseg_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_in_segment = rsp_inseg_ff;

endmodule

`default_nettype wire
